### rtl/credential_id_update_unit_assert.svh
// Assertion macros shared by the credential id update unit.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef CREDENTIAL_ID_UPDATE_UNIT_ASSERT_SVH
`define CREDENTIAL_ID_UPDATE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CIDU_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CIDU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/cidu_pkg.sv
// Shared types and constants for the credential id update unit.
// No dependencies; used by the controller, the datapath and the top level.
package cidu_pkg;

    localparam int unsigned ID_W = 32;

    // All ones in a re/res request leaves the id unchanged.
    localparam logic [ID_W-1:0] ID_KEEP = {ID_W{1'b1}};
    // The root id; an effective user id of root is privileged.
    localparam logic [ID_W-1:0] ID_ROOT = '0;

    // Request codes. The code left over acts as a query.
    typedef enum logic [2:0] {
        FUNC_SET_UID     = 3'd0,
        FUNC_SET_GID     = 3'd1,
        FUNC_SET_RE_UID  = 3'd2,
        FUNC_SET_RE_GID  = 3'd3,
        FUNC_SET_RES_UID = 3'd4,
        FUNC_SET_RES_GID = 3'd5,
        FUNC_QUERY       = 3'd6
    } func_t;

    // Result status codes.
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EPERM = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the request fields
        logic commit;  // evaluate the request and update the ids
    } cidu_cmd_t;

endpackage

### rtl/cidu_ctrl.sv
// Controller state machine of the credential id update unit.
// Depends on cidu_pkg for the command struct.
module cidu_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    output cidu_pkg::cidu_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;
    logic   done_reg;
    logic   done_next;
    logic   accept;

    // A transaction is taken when start is seen while idle.
    assign accept = start && !busy_reg;

    // Next state and registered outputs.
    always_comb
    begin
        state_next = state_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                    busy_next  = 1'b1;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_RESP;
                done_next  = 1'b1;
            end
            ST_RESP:
            begin
                state_next = ST_IDLE;
                busy_next  = 1'b0;
            end
            default:
            begin
                state_next = ST_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    // Datapath commands.
    always_comb
    begin
        cmd.load   = accept;
        cmd.commit = (state_reg == ST_EXEC);
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

### rtl/cidu_datapath.sv
// Datapath of the credential id update unit: request registers, the eight
// credential registers and the permission checks. Depends on cidu_pkg.
module cidu_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cidu_pkg::cidu_cmd_t           cmd,
    input  logic [2:0]                    func,
    input  logic [cidu_pkg::ID_W-1:0]     id_a,
    input  logic [cidu_pkg::ID_W-1:0]     id_b,
    input  logic [cidu_pkg::ID_W-1:0]     id_c,
    output logic                          status,
    output logic [cidu_pkg::ID_W-1:0]     real_uid,
    output logic [cidu_pkg::ID_W-1:0]     eff_uid,
    output logic [cidu_pkg::ID_W-1:0]     saved_uid,
    output logic [cidu_pkg::ID_W-1:0]     fs_uid,
    output logic [cidu_pkg::ID_W-1:0]     real_gid,
    output logic [cidu_pkg::ID_W-1:0]     eff_gid,
    output logic [cidu_pkg::ID_W-1:0]     saved_gid,
    output logic [cidu_pkg::ID_W-1:0]     fs_gid
);

    logic [2:0]                func_reg;
    logic [cidu_pkg::ID_W-1:0] a_reg;
    logic [cidu_pkg::ID_W-1:0] b_reg;
    logic [cidu_pkg::ID_W-1:0] c_reg;

    logic [cidu_pkg::ID_W-1:0] ruid_reg;
    logic [cidu_pkg::ID_W-1:0] euid_reg;
    logic [cidu_pkg::ID_W-1:0] suid_reg;
    logic [cidu_pkg::ID_W-1:0] fuid_reg;
    logic [cidu_pkg::ID_W-1:0] rgid_reg;
    logic [cidu_pkg::ID_W-1:0] egid_reg;
    logic [cidu_pkg::ID_W-1:0] sgid_reg;
    logic [cidu_pkg::ID_W-1:0] fgid_reg;
    logic                      status_reg;

    logic                      priv;
    logic                      grp;
    logic                      set_op;
    logic                      fail;
    logic [cidu_pkg::ID_W-1:0] cur_r;
    logic [cidu_pkg::ID_W-1:0] cur_e;
    logic [cidu_pkg::ID_W-1:0] cur_s;
    logic [cidu_pkg::ID_W-1:0] cur_f;
    logic [cidu_pkg::ID_W-1:0] r_next;
    logic [cidu_pkg::ID_W-1:0] e_next;
    logic [cidu_pkg::ID_W-1:0] s_next;
    logic [cidu_pkg::ID_W-1:0] f_next;

    logic a_keep;
    logic b_keep;
    logic c_keep;
    logic a_in_set;
    logic b_in_set;
    logic c_in_set;

    // Capture the request fields when a transaction is accepted.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            a_reg    <= id_a;
            b_reg    <= id_b;
            c_reg    <= id_c;
        end
    end

    // The caller is privileged only when the effective user id is root.
    assign priv = (euid_reg == cidu_pkg::ID_ROOT);

    // Odd set codes act on the group ids.
    assign grp = (func_reg == cidu_pkg::FUNC_SET_GID)
              || (func_reg == cidu_pkg::FUNC_SET_RE_GID)
              || (func_reg == cidu_pkg::FUNC_SET_RES_GID);

    assign cur_r = grp ? rgid_reg : ruid_reg;
    assign cur_e = grp ? egid_reg : euid_reg;
    assign cur_s = grp ? sgid_reg : suid_reg;
    assign cur_f = grp ? fgid_reg : fuid_reg;

    assign a_keep = (a_reg == cidu_pkg::ID_KEEP);
    assign b_keep = (b_reg == cidu_pkg::ID_KEEP);
    assign c_keep = (c_reg == cidu_pkg::ID_KEEP);

    // Whether each requested id is already one of real, effective or saved.
    assign a_in_set = (a_reg == cur_r) || (a_reg == cur_e) || (a_reg == cur_s);
    assign b_in_set = (b_reg == cur_r) || (b_reg == cur_e) || (b_reg == cur_s);
    assign c_in_set = (c_reg == cur_r) || (c_reg == cur_e) || (c_reg == cur_s);

    // New ids of the selected bank and the permission check.
    always_comb
    begin
        r_next = cur_r;
        e_next = cur_e;
        s_next = cur_s;
        f_next = cur_f;
        fail   = 1'b0;
        set_op = 1'b1;
        unique case (func_reg)
            cidu_pkg::FUNC_SET_UID,
            cidu_pkg::FUNC_SET_GID:
            begin
                if (priv)
                begin
                    r_next = a_reg;
                    e_next = a_reg;
                    s_next = a_reg;
                    f_next = a_reg;
                end
                else if ((a_reg == cur_r) || (a_reg == cur_s))
                begin
                    e_next = a_reg;
                    f_next = a_reg;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            cidu_pkg::FUNC_SET_RE_UID,
            cidu_pkg::FUNC_SET_RE_GID:
            begin
                if (!priv)
                begin
                    if (!a_keep && (a_reg != cur_r) && (a_reg != cur_e))
                    begin
                        fail = 1'b1;
                    end
                    if (!b_keep && !b_in_set)
                    begin
                        fail = 1'b1;
                    end
                end
                r_next = a_keep ? cur_r : a_reg;
                e_next = b_keep ? cur_e : b_reg;
                f_next = e_next;
                // A changed effective id is also kept as the saved id.
                if (!b_keep && (b_reg != cur_e))
                begin
                    s_next = b_reg;
                end
            end
            cidu_pkg::FUNC_SET_RES_UID,
            cidu_pkg::FUNC_SET_RES_GID:
            begin
                if (!priv)
                begin
                    if ((!a_keep && !a_in_set) || (!b_keep && !b_in_set)
                        || (!c_keep && !c_in_set))
                    begin
                        fail = 1'b1;
                    end
                end
                if (!a_keep)
                begin
                    r_next = a_reg;
                end
                if (!b_keep)
                begin
                    e_next = b_reg;
                    f_next = b_reg;
                end
                if (!c_keep)
                begin
                    s_next = c_reg;
                end
            end
            default:
            begin
                // Query and the unused code change nothing.
                set_op = 1'b0;
            end
        endcase
    end

    // Credential registers and the result status.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ruid_reg   <= cidu_pkg::ID_ROOT;
            euid_reg   <= cidu_pkg::ID_ROOT;
            suid_reg   <= cidu_pkg::ID_ROOT;
            fuid_reg   <= cidu_pkg::ID_ROOT;
            rgid_reg   <= cidu_pkg::ID_ROOT;
            egid_reg   <= cidu_pkg::ID_ROOT;
            sgid_reg   <= cidu_pkg::ID_ROOT;
            fgid_reg   <= cidu_pkg::ID_ROOT;
            status_reg <= cidu_pkg::STATUS_OK;
        end
        else if (cmd.commit)
        begin
            status_reg <= fail ? cidu_pkg::STATUS_EPERM : cidu_pkg::STATUS_OK;
            if (set_op && !fail)
            begin
                if (grp)
                begin
                    rgid_reg <= r_next;
                    egid_reg <= e_next;
                    sgid_reg <= s_next;
                    fgid_reg <= f_next;
                end
                else
                begin
                    ruid_reg <= r_next;
                    euid_reg <= e_next;
                    suid_reg <= s_next;
                    fuid_reg <= f_next;
                end
            end
        end
    end

    assign status    = status_reg;
    assign real_uid  = ruid_reg;
    assign eff_uid   = euid_reg;
    assign saved_uid = suid_reg;
    assign fs_uid    = fuid_reg;
    assign real_gid  = rgid_reg;
    assign eff_gid   = egid_reg;
    assign saved_gid = sgid_reg;
    assign fs_gid    = fgid_reg;

endmodule

### rtl/credential_id_update_unit.sv
// Top level of the credential id update unit: controller plus datapath.
// Depends on cidu_pkg, cidu_ctrl, cidu_datapath and the assertion macro header.
//
// Channel    Handshake            Fields
// request    start, busy          func, id_a, id_b, id_c
// result     done (one cycle)     status, real_uid .. fs_gid
//
// A transaction is taken at a clock edge with start high and busy low.
// Each request passes through capture, evaluate and update, then the
// result cycle with done high; busy is low again in the cycle after done.
// The controller state machine fixes this; a new request is not taken until busy is low again.
// Reset puts all eight ids at root (zero) and leaves the unit idle.
// The receiver cannot stall; each result is shown for exactly one cycle.
`include "credential_id_update_unit_assert.svh"

module credential_id_update_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    func,
    input  logic [cidu_pkg::ID_W-1:0]     id_a,
    input  logic [cidu_pkg::ID_W-1:0]     id_b,
    input  logic [cidu_pkg::ID_W-1:0]     id_c,
    output logic                          done,
    output logic                          status,
    output logic [cidu_pkg::ID_W-1:0]     real_uid,
    output logic [cidu_pkg::ID_W-1:0]     eff_uid,
    output logic [cidu_pkg::ID_W-1:0]     saved_uid,
    output logic [cidu_pkg::ID_W-1:0]     fs_uid,
    output logic [cidu_pkg::ID_W-1:0]     real_gid,
    output logic [cidu_pkg::ID_W-1:0]     eff_gid,
    output logic [cidu_pkg::ID_W-1:0]     saved_gid,
    output logic [cidu_pkg::ID_W-1:0]     fs_gid
);

    cidu_pkg::cidu_cmd_t cmd;

    // Sequencer.
    cidu_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // Credential registers and checks.
    cidu_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .func      (func),
        .id_a      (id_a),
        .id_b      (id_b),
        .id_c      (id_c),
        .status    (status),
        .real_uid  (real_uid),
        .eff_uid   (eff_uid),
        .saved_uid (saved_uid),
        .fs_uid    (fs_uid),
        .real_gid  (real_gid),
        .eff_gid   (eff_gid),
        .saved_gid (saved_gid),
        .fs_gid    (fs_gid)
    );

    // An accepted request makes the unit busy in the next cycle.
    `CIDU_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
    // A result is shown for one cycle and the unit is then free.
    `CIDU_ASSERT_NEXT(a_done_release, done, !done && !busy, "done not followed by idle")
    // A result only appears while a request is in flight.
    `CIDU_ASSERT_SAME(a_done_busy, done, busy, "done outside a request")
    // A privileged caller is never refused.
    `CIDU_ASSERT_SAME(a_priv_ok, done && status, $past(eff_uid) != cidu_pkg::ID_ROOT,
        "privileged request refused")
    // A refused request leaves every id as it was.
    `CIDU_ASSERT_SAME(a_refuse_hold, done && status,
        $stable(real_uid) && $stable(eff_uid) && $stable(saved_uid) && $stable(fs_uid)
        && $stable(real_gid) && $stable(eff_gid) && $stable(saved_gid) && $stable(fs_gid),
        "refused request changed an id")

endmodule

### tb/credential_id_update_unit_test.sv
// Self-checking testbench for credential_id_update_unit: directed and random transactions.
// Depends on cidu_pkg and the credential_id_update_unit RTL; predicts each result in-line.
module credential_id_update_unit_test;
    import cidu_pkg::*;

    // The leftover request code behaves as a query.
    localparam logic [2:0] FUNC_UNUSED = 3'd7;
    localparam int RANDOM_ITEMS = 600;
    localparam int TAIL_CYCLES  = 8;
    localparam int LIMIT_TIME   = 400000;

    typedef logic [ID_W-1:0] cred_id_t;

    // One group of ids: real, effective, saved and filesystem.
    typedef struct packed {
        cred_id_t r_id;
        cred_id_t e_id;
        cred_id_t s_id;
        cred_id_t f_id;
    } id_set_t;

    typedef struct packed {
        id_set_t usr;
        id_set_t grp;
    } cred_t;

    typedef struct packed {
        logic [2:0] func;
        cred_id_t   a;
        cred_id_t   b;
        cred_id_t   c;
    } cred_req_t;

    typedef struct packed {
        logic    status;
        id_set_t ids;
    } set_outcome_t;

    typedef struct packed {
        logic  status;
        cred_t ids;
    } cred_resp_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    logic [2:0] func = '0;
    cred_id_t id_a = '0;
    cred_id_t id_b = '0;
    cred_id_t id_c = '0;
    logic     done;
    logic     status;
    cred_id_t real_uid, eff_uid, saved_uid, fs_uid;
    cred_id_t real_gid, eff_gid, saved_gid, fs_gid;

    cred_req_t  pending_reqs[$];
    cred_resp_t expected_creds[$];
    cred_t      model_creds = '0;
    cred_t      plan_creds = '0;
    int         total_items = 0;
    int         accepted_count = 0;
    int         fail_count = 0;
    int         burst_left = 0;
    int         gap_left = 0;

    credential_id_update_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .func      (func),
        .id_a      (id_a),
        .id_b      (id_b),
        .id_c      (id_c),
        .done      (done),
        .status    (status),
        .real_uid  (real_uid),
        .eff_uid   (eff_uid),
        .saved_uid (saved_uid),
        .fs_uid    (fs_uid),
        .real_gid  (real_gid),
        .eff_gid   (eff_gid),
        .saved_gid (saved_gid),
        .fs_gid    (fs_gid)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // True when the value already sits in the real, effective or saved id.
    function automatic logic is_held(cred_id_t v, id_set_t cur);
        return v == cur.r_id || v == cur.e_id || v == cur.s_id;
    endfunction

    // Applies one request to a single group of ids.
    function automatic set_outcome_t update_id_set(id_set_t cur, logic priv, logic [2:0] op,
                                                   cred_id_t a, cred_id_t b, cred_id_t c);
        set_outcome_t o;
        cred_id_t     new_eff;
        o.status = STATUS_OK;
        o.ids    = cur;
        case (op)
            FUNC_SET_UID, FUNC_SET_GID:
            begin
                // All ones is an ordinary value here.
                if (priv)
                    o.ids = '{a, a, a, a};
                else if (a == cur.r_id || a == cur.s_id)
                begin
                    o.ids.e_id = a;
                    o.ids.f_id = a;
                end
                else
                    o.status = STATUS_EPERM;
            end
            FUNC_SET_RE_UID, FUNC_SET_RE_GID:
            begin
                if (!priv && ((a != ID_KEEP && a != cur.r_id && a != cur.e_id) ||
                              (b != ID_KEEP && !is_held(b, cur))))
                    o.status = STATUS_EPERM;
                else
                begin
                    new_eff = (b == ID_KEEP) ? cur.e_id : b;
                    // A changed effective id is copied into the saved id.
                    if (b != ID_KEEP && new_eff != cur.e_id)
                        o.ids.s_id = new_eff;
                    if (a != ID_KEEP)
                        o.ids.r_id = a;
                    o.ids.e_id = new_eff;
                    o.ids.f_id = new_eff;
                end
            end
            FUNC_SET_RES_UID, FUNC_SET_RES_GID:
            begin
                if (!priv && ((a != ID_KEEP && !is_held(a, cur)) ||
                              (b != ID_KEEP && !is_held(b, cur)) ||
                              (c != ID_KEEP && !is_held(c, cur))))
                    o.status = STATUS_EPERM;
                else
                begin
                    if (a != ID_KEEP)
                        o.ids.r_id = a;
                    if (b != ID_KEEP)
                    begin
                        o.ids.e_id = b;
                        o.ids.f_id = b;
                    end
                    if (c != ID_KEEP)
                        o.ids.s_id = c;
                end
            end
            default:
            begin
            end
        endcase
        return o;
    endfunction

    // Predicts the status and all eight ids after one transaction.
    function automatic cred_resp_t next_creds(cred_t cur, cred_req_t rq);
        cred_resp_t   r;
        set_outcome_t o;
        logic         priv;
        priv     = (cur.usr.e_id == ID_ROOT);
        r.status = STATUS_OK;
        r.ids    = cur;
        case (rq.func)
            FUNC_SET_UID, FUNC_SET_RE_UID, FUNC_SET_RES_UID:
            begin
                o        = update_id_set(cur.usr, priv, rq.func, rq.a, rq.b, rq.c);
                r.status = o.status;
                r.ids.usr = o.ids;
            end
            FUNC_SET_GID, FUNC_SET_RE_GID, FUNC_SET_RES_GID:
            begin
                o        = update_id_set(cur.grp, priv, rq.func, rq.a, rq.b, rq.c);
                r.status = o.status;
                r.ids.grp = o.ids;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Picks an id that often matches one already held, so unprivileged requests pass.
    function automatic cred_id_t pick_id(id_set_t s);
        int k;
        k = $urandom_range(0, 19);
        if (k < 5)
            return ID_KEEP;
        if (k < 13)
        begin
            case ($urandom_range(0, 3))
                0: return s.r_id;
                1: return s.e_id;
                2: return s.s_id;
                default: return s.f_id;
            endcase
        end
        if (k < 16)
            return cred_id_t'($urandom_range(0, 3));
        return $urandom;
    endfunction

    function automatic logic root_reachable(id_set_t s);
        return s.r_id == ID_ROOT || s.e_id == ID_ROOT || s.s_id == ID_ROOT;
    endfunction

    task automatic add_req(logic [2:0] f, cred_id_t a, cred_id_t b, cred_id_t c);
        cred_req_t  rq;
        cred_resp_t nxt;
        rq  = '{f, a, b, c};
        nxt = next_creds(plan_creds, rq);
        plan_creds = nxt.ids;
        pending_reqs.push_back(rq);
    endtask

    // Stimulus: directed transactions, then random ones, then the end of the run.
    initial
    begin
        cred_req_t  rq;
        cred_resp_t nxt;
        id_set_t    tgt;
        int         roll;
        int         tries;

        // Directed: queries, every operation, privileged and refused cases.
        add_req(FUNC_QUERY, '0, '0, '0);
        add_req(FUNC_UNUSED, $urandom, $urandom, $urandom);
        add_req(FUNC_SET_GID, ID_KEEP, '0, '0);
        add_req(FUNC_SET_RE_GID, 32'd5, 32'd9, $urandom);
        add_req(FUNC_SET_RES_GID, 32'd0, ID_KEEP, 32'd7);
        add_req(FUNC_SET_RES_UID, 32'd100, 32'd200, 32'd0);
        add_req(FUNC_SET_UID, 32'd100, $urandom, $urandom);
        add_req(FUNC_SET_UID, 32'd200, '0, '0);
        add_req(FUNC_SET_UID, ID_KEEP, '0, '0);
        add_req(FUNC_SET_RE_UID, 32'd5, ID_KEEP, '0);
        add_req(FUNC_SET_RE_GID, 32'd7, 32'd9, '0);
        add_req(FUNC_SET_RE_GID, 32'd9, 32'd7, '0);
        add_req(FUNC_SET_GID, 32'd9, '0, '0);
        add_req(FUNC_SET_RES_GID, 32'd1, ID_KEEP, ID_KEEP);
        add_req(FUNC_SET_RES_GID, ID_KEEP, ID_KEEP, ID_KEEP);
        add_req(FUNC_SET_RE_UID, ID_KEEP, 32'd0, '0);
        add_req(FUNC_SET_RES_UID, ID_KEEP, ID_KEEP, ID_KEEP);
        add_req(FUNC_SET_UID, 32'd0, '0, '0);
        add_req(FUNC_SET_RES_GID, 32'hFFFF_FFFE, 32'h8000_0000, 32'h0000_0001);
        add_req(FUNC_SET_RES_UID, 32'd0, 32'hFFFF_FFFE, 32'h5555_5555);
        add_req(FUNC_SET_UID, 32'd0, ID_KEEP, ID_KEEP);
        add_req(FUNC_SET_GID, 32'hAAAA_AAAA, 32'h5555_5555, ID_KEEP);

        // Random: mostly plausible ids, some noise; keep root reachable until near the end.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            tries = 0;
            do
            begin
                roll = $urandom_range(0, 99);
                if (roll < 12)
                    rq = '{3'($urandom_range(0, 7)), $urandom, $urandom, $urandom};
                else if (roll < 20)
                    rq = '{FUNC_SET_RES_UID, ID_KEEP, ID_ROOT, ID_KEEP};
                else
                begin
                    rq.func = 3'($urandom_range(0, 6));
                    tgt = (rq.func == FUNC_SET_GID || rq.func == FUNC_SET_RE_GID ||
                           rq.func == FUNC_SET_RES_GID) ? plan_creds.grp : plan_creds.usr;
                    rq.a = pick_id(tgt);
                    rq.b = pick_id(tgt);
                    rq.c = pick_id(tgt);
                end
                nxt = next_creds(plan_creds, rq);
                tries++;
            end
            while (tries < 8 && i < RANDOM_ITEMS - 40 && !root_reachable(nxt.ids.usr));
            if (i < RANDOM_ITEMS - 40 && !root_reachable(nxt.ids.usr))
                rq = '{FUNC_QUERY, $urandom, $urandom, $urandom};
            add_req(rq.func, rq.a, rq.b, rq.c);
        end
        total_items = pending_reqs.size();

        // Wait for every transaction to be taken and every result to arrive.
        @(posedge rst_n);
        while (accepted_count < total_items)
            @(posedge clk);
        while (expected_creds.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Driver: presents queued requests in bursts with random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        cred_req_t  rq;
        cred_resp_t nxt;
        if (!rst_n)
        begin
            start      <= 1'b0;
            func       <= '0;
            id_a       <= '0;
            id_b       <= '0;
            id_c       <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            // A transaction is taken: predict its result.
            if (start && !busy)
            begin
                rq  = pending_reqs.pop_front();
                nxt = next_creds(model_creds, rq);
                model_creds = nxt.ids;
                expected_creds.push_back(nxt);
                accepted_count++;
            end
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    rq    = pending_reqs[0];
                    func  <= rq.func;
                    id_a  <= rq.a;
                    id_b  <= rq.b;
                    id_c  <= rq.c;
                    start <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    // Start a new burst; some bursts are long, and some draw no gap.
                    if (burst_left == 0)
                    begin
                        burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    start <= 1'b0;
            end
        end
    end

    task automatic check_field(string name, cred_id_t exp_val, cred_id_t act_val);
        if (exp_val !== act_val)
        begin
            $error("%s: expected %h, got %h", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    // Monitor: each result strobe is compared with the oldest prediction.
    always @(posedge clk)
    begin
        cred_resp_t want;
        if (rst_n && done)
        begin
            if (expected_creds.size() == 0)
            begin
                $error("result transaction with no request outstanding");
                fail_count++;
            end
            else
            begin
                want = expected_creds.pop_front();
                check_field("status", cred_id_t'(want.status), cred_id_t'(status));
                check_field("real_uid", want.ids.usr.r_id, real_uid);
                check_field("eff_uid", want.ids.usr.e_id, eff_uid);
                check_field("saved_uid", want.ids.usr.s_id, saved_uid);
                check_field("fs_uid", want.ids.usr.f_id, fs_uid);
                check_field("real_gid", want.ids.grp.r_id, real_gid);
                check_field("eff_gid", want.ids.grp.e_id, eff_gid);
                check_field("saved_gid", want.ids.grp.s_id, saved_gid);
                check_field("fs_gid", want.ids.grp.f_id, fs_gid);
            end
        end
    end

    // Watchdog for a hung run.
    initial
    begin
        #LIMIT_TIME;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
